@@ src/owhtd_pkg.sv @@
// Shared types and constants for the single-wire humidity and temperature frame decoder.
`default_nettype none
package owhtd_pkg;
   localparam int FRAME_BITS = 40;
   localparam int BIT_W = 6;
   localparam int NUM_BYTES = 5;
   localparam logic [7:0] TIMEOUT_DUR = 8'hFF;
   localparam logic [7:0] THRESH_RESET = 8'd50;
   localparam logic [7:0] TRANS_RESET = 8'd85;
   localparam logic [0:0] REG_THRESH = 1'b0;
   localparam logic [0:0] REG_TRANS = 1'b1;
   localparam logic MODE_START = 1'b0;
   localparam logic [15:0] DIV10_RECIP = 16'd52429;
   localparam int DIV10_SHIFT = 19;

   typedef struct packed {
      logic timed_out;
      logic [BIT_W-1:0] bits;
      logic [NUM_BYTES-1:0][7:0] bytes;
   } event_type;
endpackage
`default_nettype wire

@@ src/owhtd_frame.sv @@
// Frame state tracker: shifts data bits in and captures a frame-end event.
`default_nettype none
module owhtd_frame (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic accept,
   input  wire logic mode,
   input  wire logic [7:0] duration,
   input  wire logic [7:0] one_threshold,
   input  wire logic [7:0] frame_transitions,
   input  wire logic ev_take,
   output logic ev_valid,
   output owhtd_pkg::event_type ev
);
   import owhtd_pkg::*;

   logic [NUM_BYTES-1:0][7:0] bytes_ff, bytes_in;
   logic [7:0] trans_ff, trans_in;
   logic [BIT_W-1:0] bits_ff, bits_in;
   logic active_ff, active_in;
   logic ev_valid_ff, ev_valid_in;
   event_type ev_ff, ev_in;
   logic emit;
   logic timeout;
   logic [8:0] trans_next;
   logic [2:0] byte_sel;

   assign trans_next = {1'b0, trans_ff} + 9'd1;
   assign byte_sel = bits_ff[BIT_W-1:3];

   always_comb begin
      bytes_in = bytes_ff;
      trans_in = trans_ff;
      bits_in = bits_ff;
      active_in = active_ff;
      emit = 1'b0;
      timeout = 1'b0;
      if (accept) begin
         if (mode == MODE_START) begin
            bytes_in = '0;
            trans_in = '0;
            bits_in = '0;
            active_in = 1'b1;
         end else if (active_ff) begin
            if (duration == TIMEOUT_DUR) begin
               active_in = 1'b0;
               emit = 1'b1;
               timeout = 1'b1;
            end else begin
               if (trans_ff >= 8'd4 && !trans_ff[0] && bits_ff < BIT_W'(FRAME_BITS)) begin
                  bytes_in[byte_sel] = {bytes_ff[byte_sel][6:0], duration > one_threshold};
                  bits_in = bits_ff + BIT_W'(1);
               end
               if (trans_next >= {1'b0, frame_transitions}) begin
                  if (trans_ff != 8'hFF) begin
                     trans_in = trans_next[7:0];
                  end
                  active_in = 1'b0;
                  emit = 1'b1;
               end else begin
                  trans_in = trans_next[7:0];
               end
            end
         end
      end
   end

   always_comb begin
      ev_in = ev_ff;
      ev_valid_in = ev_valid_ff;
      if (ev_take) begin
         ev_valid_in = 1'b0;
      end
      if (emit) begin
         ev_valid_in = 1'b1;
         ev_in.timed_out = timeout;
         ev_in.bits = bits_in;
         ev_in.bytes = bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= '0;
         trans_ff <= '0;
         bits_ff <= '0;
         active_ff <= 1'b0;
         ev_valid_ff <= 1'b0;
      end else begin
         bytes_ff <= bytes_in;
         trans_ff <= trans_in;
         bits_ff <= bits_in;
         active_ff <= active_in;
         ev_valid_ff <= ev_valid_in;
      end
      ev_ff <= ev_in;
   end

   assign ev_valid = ev_valid_ff;
   assign ev = ev_ff;
endmodule
`default_nettype wire

@@ src/owhtd_format.sv @@
// Result formatter: checksum, humidity and temperature fields into the result register.
`default_nettype none
module owhtd_format (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic ev_valid,
   input  wire owhtd_pkg::event_type ev,
   input  wire logic out_ready,
   output logic ev_take,
   output logic out_valid,
   output logic frame_good,
   output logic [5:0] bits_received,
   output logic timed_out,
   output logic [15:0] humidity_tenths,
   output logic signed [15:0] temp_tenths,
   output logic signed [12:0] temp_whole
);
   import owhtd_pkg::*;

   logic [7:0] b0, b1, b2, b3, b4;
   logic [7:0] sum;
   logic [14:0] mag;
   logic [30:0] prod;
   logic [11:0] whole;
   logic valid_ff, valid_in;
   logic good_ff, good_in;
   logic [5:0] bits_ff;
   logic tmo_ff;
   logic [15:0] hum_ff, hum_in;
   logic [15:0] tt_ff, tt_in;
   logic [12:0] tw_ff, tw_in;

   assign b0 = ev.bytes[0];
   assign b1 = ev.bytes[1];
   assign b2 = ev.bytes[2];
   assign b3 = ev.bytes[3];
   assign b4 = ev.bytes[4];
   assign sum = b0 + b1 + b2 + b3;
   assign mag = {b2[6:0], b3};
   assign prod = {16'd0, mag} * {15'd0, DIV10_RECIP};
   assign whole = prod[DIV10_SHIFT +: 12];

   assign good_in = (ev.bits >= BIT_W'(FRAME_BITS)) && (b4 == sum);
   assign hum_in = {b0, b1};
   assign tt_in = b2[7] ? 16'(-{1'b0, mag}) : {1'b0, mag};
   assign tw_in = b2[7] ? 13'(-{1'b0, whole}) : {1'b0, whole};

   assign ev_take = ev_valid && (!valid_ff || out_ready);
   assign valid_in = ev_take || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (ev_take) begin
         good_ff <= good_in;
         bits_ff <= ev.bits;
         tmo_ff <= ev.timed_out;
         hum_ff <= hum_in;
         tt_ff <= tt_in;
         tw_ff <= tw_in;
      end
   end

   assign out_valid = valid_ff;
   assign frame_good = good_ff;
   assign bits_received = bits_ff;
   assign timed_out = tmo_ff;
   assign humidity_tenths = hum_ff;
   assign temp_tenths = tt_ff;
   assign temp_whole = tw_ff;
endmodule
`default_nettype wire

@@ src/one_wire_humidity_temp_decoder_top.sv @@
// Top level of the single-wire humidity and temperature frame decoder.
// The decoder takes one beat per clock cycle while req_tready is high. A start beat (tuser 0)
// opens a frame; each following beat carries one measured level duration. A frame ends on a
// timeout duration of 255 or after the configured number of transitions. The frame-end beat
// first loads the frame event register. The result register then loads from it, through the
// divide-by-ten multiplier, once it is empty or its beat is being taken. Input beats keep
// flowing while a result waits. When a frame event is also held behind a stalled result,
// req_tready stays low until the result beat is taken. The user must write the one-bit
// threshold and the transition count through the csr port only while the block idles; the
// block itself does not enforce it.
`default_nettype none
module one_wire_humidity_temp_decoder_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [7:0] req_tdata,    // duration[7:0]
   input  wire logic req_tuser,          // mode[0]
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [55:0] rsp_tdata,        // bits_received[5:0], humidity_tenths[21:6],
                                         // temp_tenths[37:22], temp_whole[50:38], zeros
   output logic [1:0] rsp_tuser,         // frame_good[0], timed_out[1]
   input  wire logic csr_we,
   input  wire logic [0:0] csr_addr,
   input  wire logic [7:0] csr_wdata
);
   import owhtd_pkg::*;

   logic [7:0] thresh_ff, thresh_in;
   logic [7:0] trans_ff, trans_in;
   logic accept;
   logic ev_valid, ev_take;
   event_type ev;
   logic frame_good, timed_out;
   logic [5:0] bits_received;
   logic [15:0] humidity_tenths;
   logic signed [15:0] temp_tenths;
   logic signed [12:0] temp_whole;

   always_comb begin
      thresh_in = thresh_ff;
      trans_in = trans_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_THRESH: thresh_in = csr_wdata;
            REG_TRANS: trans_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         trans_ff <= TRANS_RESET;
      end else begin
         thresh_ff <= thresh_in;
         trans_ff <= trans_in;
      end
   end

   assign req_tready = !ev_valid || ev_take;
   assign accept = req_tvalid && req_tready;

   owhtd_frame u_frame (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .mode(req_tuser),
      .duration(req_tdata),
      .one_threshold(thresh_ff),
      .frame_transitions(trans_ff),
      .ev_take(ev_take),
      .ev_valid(ev_valid),
      .ev(ev)
   );

   owhtd_format u_format (
      .clock(clock),
      .reset(reset),
      .ev_valid(ev_valid),
      .ev(ev),
      .out_ready(rsp_tready),
      .ev_take(ev_take),
      .out_valid(rsp_tvalid),
      .frame_good(frame_good),
      .bits_received(bits_received),
      .timed_out(timed_out),
      .humidity_tenths(humidity_tenths),
      .temp_tenths(temp_tenths),
      .temp_whole(temp_whole)
   );

   assign rsp_tdata = {5'd0, temp_whole, temp_tenths, humidity_tenths, bits_received};
   assign rsp_tuser = {timed_out, frame_good};
endmodule
`default_nettype wire
